/* src/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, constants and controller/datapath interface types for the
// modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int MOD_W        = 31;
  localparam int BASE_W       = 32;
  localparam int EXP_BITS_DEF = 32;
  localparam int PROD_W       = 64;
  localparam int RED_DIGITS   = 4;
  localparam int RED_STEPS    = PROD_W / RED_DIGITS;
  localparam int RED_CNT_W    = $clog2(RED_STEPS);

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd998244353;

  // Multiplier operand select
  typedef enum logic {
    MUL_ACC,
    MUL_SQ
  } mul_sel_t;

  typedef struct packed {
    logic     load;      // take a new item, start reducing the base
    logic     mult;      // form a product and restart the reducer
    mul_sel_t sel;       // product operands
    logic     step;      // advance the reducer by one digit group
    logic     wr_acc;    // write the remainder into the accumulator
    logic     wr_sq;     // write the remainder into the running square
    logic     shift_e;   // drop the exponent's low bit
    logic     load_out;  // load the output register
    logic     out_zero;  // load zero instead of the accumulator
  } ctrl_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic rem_zero;
    logic exp_zero;
    logic exp_lsb;
    logic exp_last;   // no exponent bits above the low one
    logic red_last;   // reducer is on its final step
  } ctrl_sts_t;

endpackage

/* src/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One item at a time: an accepted (base, exponent) pair yields one
// result_value, held in an output register so the next item can be taken
// while the result still waits for its transfer. All modular products go
// through one shared 31x31 multiplier followed by a restoring reducer that
// retires four product bits per cycle. An item first reduces the base
// modulo the modulus; then, for each exponent bit from the low end, a set
// bit multiplies the accumulator by the running square and every bit
// below the highest set bit squares the running square; the squaring
// after the highest set bit is skipped. An exponent of zero, a base that
// reduces to zero or a zero modulus skips the square-and-multiply steps.
// The modulus register resets to 998244353 and is written through
// cfg_write/cfg_data; the user must write it only while the block is idle,
// which is the user's duty, unenforced by the block itself. A zero modulus
// gives a zero result for every item.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [mexp_pkg::MOD_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mexp_pkg::BASE_W-1:0] base,
  input  logic [EXP_BITS-1:0]         exponent,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mexp_pkg::MOD_W-1:0]  result_value
);
  import mexp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence the work and own both handshakes
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold operands, multiply, reduce and hold the result
  mexp_dp #(
    .EXP_BITS (EXP_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .base         (base),
    .exponent     (exponent),
    .cmd          (cmd),
    .sts          (sts),
    .result_value (result_value)
  );

endmodule

/* src/mexp_dp.sv */
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: modulus register, accumulator, running square, exponent shifter,
// one 31x31 multiplier and a restoring reducer that retires four bits a cycle.
// ----------------------------------------------------------------------------
module mexp_dp #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [mexp_pkg::MOD_W-1:0]  cfg_data,
  input  logic [mexp_pkg::BASE_W-1:0] base,
  input  logic [EXP_BITS-1:0]         exponent,
  input  mexp_pkg::ctrl_cmd_t         cmd,
  output mexp_pkg::ctrl_sts_t         sts,
  output logic [mexp_pkg::MOD_W-1:0]  result_value
);
  import mexp_pkg::*;

  logic [MOD_W-1:0]     modulus;
  logic [MOD_W-1:0]     acc;
  logic [MOD_W-1:0]     sq;
  logic [EXP_BITS-1:0]  e;
  logic [PROD_W-1:0]    prod;
  logic [MOD_W:0]       rem;
  logic [MOD_W:0]       rem_next;
  logic [RED_CNT_W-1:0] cnt;
  logic [MOD_W-1:0]     res;

  logic [MOD_W-1:0]     mul_a;
  logic [2*MOD_W-1:0]   mul_p;
  logic [MOD_W:0]       red_t;

  assign mul_a = (cmd.sel == MUL_ACC) ? acc : sq;
  assign mul_p = mul_a * sq;

  // Shift in the next product bits MSB first; subtract the modulus when it fits
  always_comb begin
    rem_next = rem;
    red_t    = '0;
    for (int i = 0; i < RED_DIGITS; i++) begin
      red_t = {rem_next[MOD_W-1:0], prod[PROD_W-1-i]};
      if (red_t >= {1'b0, modulus}) begin
        rem_next = red_t - {1'b0, modulus};
      end else begin
        rem_next = red_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_write) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      prod <= {{(PROD_W-BASE_W){1'b0}}, base};
      e    <= exponent;
      acc  <= MOD_W'(1);
      rem  <= '0;
      cnt  <= '0;
    end else if (cmd.mult) begin
      prod <= {{(PROD_W-2*MOD_W){1'b0}}, mul_p};
      rem  <= '0;
      cnt  <= '0;
    end else if (cmd.step) begin
      prod <= prod << RED_DIGITS;
      rem  <= rem_next;
      cnt  <= cnt + 1'b1;
    end
    if (cmd.wr_acc) begin
      acc <= rem[MOD_W-1:0];
    end
    if (cmd.wr_sq) begin
      sq <= rem[MOD_W-1:0];
    end
    if (cmd.shift_e) begin
      e <= e >> 1;
    end
    if (cmd.load_out) begin
      res <= cmd.out_zero ? '0 : acc;
    end
  end

  assign sts.mod_zero = (modulus == '0);
  assign sts.rem_zero = (rem == '0);
  assign sts.exp_zero = (e == '0);
  assign sts.exp_lsb  = e[0];
  assign sts.exp_last = ((e >> 1) == '0);
  assign sts.red_last = (cnt == RED_CNT_W'(RED_STEPS - 1));

  assign result_value = res;

endmodule

/* src/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences base reduction, square-and-multiply steps and the
// output register transfer.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output mexp_pkg::ctrl_cmd_t cmd,
  input  mexp_pkg::ctrl_sts_t sts
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_BASE,
    S_CHK_BASE,
    S_BIT,
    S_RED,
    S_WB,
    S_FINISH
  } state_t;

  state_t   state;
  state_t   state_next;
  mul_sel_t op;
  mul_sel_t op_next;
  logic     zero_res;
  logic     zero_res_next;
  logic     out_take;

  assign in_stall = (state != S_IDLE);
  assign out_take = !out_valid || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.sel       = MUL_ACC;
    state_next    = state;
    op_next       = op;
    zero_res_next = zero_res;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RED_BASE;
        end
      end
      S_RED_BASE: begin
        cmd.step = 1'b1;
        if (sts.red_last) begin
          state_next = S_CHK_BASE;
        end
      end
      S_CHK_BASE: begin
        if (sts.mod_zero || sts.rem_zero) begin
          zero_res_next = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.wr_sq     = 1'b1;
          zero_res_next = 1'b0;
          state_next    = S_BIT;
        end
      end
      S_BIT: begin
        if (sts.exp_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.mult   = 1'b1;
          cmd.sel    = sts.exp_lsb ? MUL_ACC : MUL_SQ;
          op_next    = cmd.sel;
          state_next = S_RED;
        end
      end
      S_RED: begin
        cmd.step = 1'b1;
        if (sts.red_last) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        unique case (op)
          MUL_ACC: begin
            cmd.wr_acc = 1'b1;
            if (sts.exp_last) begin
              cmd.shift_e = 1'b1;
              state_next  = S_BIT;
            end else begin
              cmd.mult   = 1'b1;
              cmd.sel    = MUL_SQ;
              op_next    = MUL_SQ;
              state_next = S_RED;
            end
          end
          MUL_SQ: begin
            cmd.wr_sq   = 1'b1;
            cmd.shift_e = 1'b1;
            state_next  = S_BIT;
          end
          default: begin
            state_next = S_BIT;
          end
        endcase
      end
      S_FINISH: begin
        if (out_take) begin
          cmd.load_out = 1'b1;
          cmd.out_zero = zero_res;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= MUL_ACC;
      zero_res  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      op       <= op_next;
      zero_res <= zero_res_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
